@@ design/slu_pkg.sv @@
// Package for the string literal unescaper: result kinds, mode codes,
// character codes and the result item type.
// Depends on nothing; imported by string_literal_unescaper.
package slu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_QUOTE = 2'd1,
    KIND_EOT   = 2'd2,
    KIND_NOQ   = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    MODE_WAIT  = 7'b0000001,
    MODE_BODY  = 7'b0000010,
    MODE_ESC   = 7'b0000100,
    MODE_ZSKIP = 7'b0001000,
    MODE_HEX1  = 7'b0010000,
    MODE_HEX2  = 7'b0100000,
    MODE_DEC   = 7'b1000000
  } mode_e;

  localparam logic [7:0] CH_EOT   = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6e;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [9:0] DEC_MAX    = 10'd255;
  localparam logic [1:0] DEC_DIGITS = 2'd3;
  localparam logic [9:0] DEC_BASE   = 10'd10;

  localparam int unsigned QUEUE_DEPTH = 3;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } res_t;

  typedef struct packed {
    logic  emit;
    res_t  res;
    mode_e mode;
  } body_t;

  function automatic res_t make_res(logic [7:0] b, kind_e k);
    res_t r;
    r.data = (k == KIND_DATA) ? b : 8'd0;
    r.kind = k;
    r.last = (k != KIND_DATA);
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_D0) && (b <= CH_D9);
  endfunction

  // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= CH_D0 && b <= CH_D9) begin
      t = b - CH_D0;
      return {1'b1, t[3:0]};
    end else if (b >= CH_LA && b <= CH_LF) begin
      t = b - CH_LA + 8'd10;
      return {1'b1, t[3:0]};
    end else if (b >= CH_UA && b <= CH_UF) begin
      t = b - CH_UA + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  // Handles a byte of literal text: ordinary data, end of text, closing quote or escape start.
  function automatic body_t body_step(logic [7:0] b);
    body_t o;
    o.emit = 1'b1;
    o.mode = MODE_BODY;
    o.res  = make_res(b, KIND_DATA);
    if (b == CH_EOT) begin
      o.res  = make_res(b, KIND_EOT);
      o.mode = MODE_WAIT;
    end else if (b == CH_QUOTE) begin
      o.res  = make_res(b, KIND_QUOTE);
      o.mode = MODE_WAIT;
    end else if (b == CH_BSL) begin
      o.emit = 1'b0;
      o.mode = MODE_ESC;
    end
    return o;
  endfunction

endpackage

@@ design/string_literal_unescaper.sv @@
// Top level of the string literal unescaper: decoder state and result queue.
// Depends on slu_pkg for types, codes and helper functions.
//
// Channel  Direction  Handshake               Payload
// input    in         in_valid_i, in_stall_o  text_byte_i
// output   out        out_valid_o, out_stall_i out_byte_o, out_kind_o, last_o
//
// Each byte is decoded in the cycle it is accepted and its results enter a three-entry
// result queue, so one byte per cycle is taken in steady state while out_stall_i is low.
// A byte that ends a decimal escape may give two results; the queue drains them one per
// cycle while out_stall_i is low. Input stalls while the queue holds two or more results.
// Reset clears the mode, the escape registers and the queue.
module string_literal_unescaper
  import slu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] out_kind_o,
  output logic       last_o
);

  mode_e      mode_q, mode_d;
  logic [3:0] nibble_q, nibble_d;
  logic [9:0] dec_q, dec_d;
  logic [1:0] cnt_q, cnt_d;

  res_t       queue_q [QUEUE_DEPTH];
  res_t       queue_d [QUEUE_DEPTH];
  logic [1:0] fill_q, fill_d;

  res_t       res0, res1;
  logic [1:0] nres;
  logic [4:0] hex;
  logic [9:0] dec_next;
  logic [7:0] dec_out;
  body_t      body;
  logic       accept, pop;
  logic [1:0] base;

  assign hex      = hex_val(text_byte_i);
  assign dec_next = (dec_q << 3) + (dec_q << 1) + {2'd0, text_byte_i - CH_D0};
  assign body     = body_step(text_byte_i);

  always_comb begin
    mode_d   = mode_q;
    nibble_d = nibble_q;
    dec_d    = dec_q;
    cnt_d    = cnt_q;
    res0     = make_res(8'd0, KIND_DATA);
    res1     = make_res(8'd0, KIND_DATA);
    nres     = 2'd0;
    dec_out  = (dec_q > DEC_MAX) ? DEC_MAX[7:0] : dec_q[7:0];
    unique case (mode_q)
      MODE_WAIT: begin
        if (text_byte_i == CH_QUOTE) begin
          mode_d = MODE_BODY;
        end else if (!is_space(text_byte_i)) begin
          res0 = make_res(8'd0, KIND_NOQ);
          nres = 2'd1;
        end
      end
      MODE_BODY: begin
        mode_d = body.mode;
        res0   = body.res;
        nres   = {1'b0, body.emit};
      end
      MODE_ESC: begin
        mode_d = MODE_BODY;
        nres   = 2'd1;
        res0   = make_res(text_byte_i, KIND_DATA);
        case (text_byte_i)
          CH_EOT: begin
            mode_d = MODE_WAIT;
            res0   = make_res(8'd0, KIND_EOT);
          end
          CH_LA: res0 = make_res(8'd7, KIND_DATA);
          CH_LB: res0 = make_res(8'd8, KIND_DATA);
          CH_LF: res0 = make_res(8'd12, KIND_DATA);
          CH_LN: res0 = make_res(8'd10, KIND_DATA);
          CH_LR: res0 = make_res(8'd13, KIND_DATA);
          CH_LT: res0 = make_res(8'd9, KIND_DATA);
          CH_LV: res0 = make_res(8'd11, KIND_DATA);
          CH_LZ: begin
            mode_d = MODE_ZSKIP;
            nres   = 2'd0;
          end
          CH_LX: begin
            mode_d = MODE_HEX1;
            nres   = 2'd0;
          end
          default: begin
            if (is_digit(text_byte_i)) begin
              dec_d  = {2'd0, text_byte_i - CH_D0};
              cnt_d  = 2'd1;
              mode_d = MODE_DEC;
              nres   = 2'd0;
            end
          end
        endcase
      end
      MODE_ZSKIP: begin
        if (!is_space(text_byte_i)) begin
          mode_d = body.mode;
          res0   = body.res;
          nres   = {1'b0, body.emit};
        end
      end
      MODE_HEX1: begin
        if (text_byte_i == CH_EOT) begin
          mode_d = MODE_WAIT;
          res0   = make_res(8'd0, KIND_EOT);
          nres   = 2'd1;
        end else if (hex[4]) begin
          nibble_d = hex[3:0];
          mode_d   = MODE_HEX2;
        end else begin
          mode_d = MODE_BODY;
        end
      end
      MODE_HEX2: begin
        if (hex[4]) begin
          mode_d = MODE_BODY;
          res0   = make_res({nibble_q, hex[3:0]}, KIND_DATA);
          nres   = 2'd1;
        end else begin
          mode_d = body.mode;
          res0   = body.res;
          nres   = {1'b0, body.emit};
        end
      end
      MODE_DEC: begin
        if (is_digit(text_byte_i) && cnt_q < DEC_DIGITS) begin
          dec_d = dec_next;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q + 2'd1 >= DEC_DIGITS) begin
            mode_d = MODE_BODY;
            res0   = make_res((dec_next > DEC_MAX) ? DEC_MAX[7:0] : dec_next[7:0],
                              KIND_DATA);
            nres   = 2'd1;
          end
        end else begin
          res0   = make_res(dec_out, KIND_DATA);
          res1   = body.res;
          mode_d = body.mode;
          nres   = body.emit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        mode_d = MODE_WAIT;
      end
    endcase
  end

  assign in_stall_o  = (fill_q >= 2'd2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (fill_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign base        = fill_q - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop && i < QUEUE_DEPTH - 1) begin
        queue_d[i] = queue_q[i + 1];
      end else begin
        queue_d[i] = queue_q[i];
      end
      if (accept && nres != 2'd0 && i == int'(base)) begin
        queue_d[i] = res0;
      end
      if (accept && nres == 2'd2 && i == int'(base) + 1) begin
        queue_d[i] = res1;
      end
    end
    fill_d = base + (accept ? nres : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_WAIT;
      nibble_q <= 4'd0;
      dec_q    <= 10'd0;
      cnt_q    <= 2'd0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (accept) begin
        mode_q   <= mode_d;
        nibble_q <= nibble_d;
        dec_q    <= dec_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_q[i] <= queue_d[i];
    end
  end

  assign out_byte_o = queue_q[0].data;
  assign out_kind_o = queue_q[0].kind;
  assign last_o     = queue_q[0].last;

endmodule
